[rtl/producer_sequence_dedup_table_assert.svh]
// Assertion macros shared by the dedup table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef PRODUCER_SEQUENCE_DEDUP_TABLE_ASSERT_SVH
`define PRODUCER_SEQUENCE_DEDUP_TABLE_ASSERT_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define PSDT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psdt assertion failed");

// Next-cycle implication checked at every clock edge outside reset.
`define PSDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psdt assertion failed");

`endif

[rtl/psdt_pkg.sv]
// Shared types and constants for the producer sequence dedup table.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package psdt_pkg;

   localparam int KEY_W   = 64;
   localparam int SEQ_W   = 64;
   localparam int STAMP_W = 32;
   localparam int CNT_W   = 5;

   typedef enum logic [1:0] {
      OP_CHECK   = 2'd0,
      OP_MARK    = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_CLEANUP = 2'd3
   } opcode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_issue;
      logic apply;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_scan;
      logic scan_last;
      logic is_cleanup;
   } status_type;

endpackage

`default_nettype wire

[rtl/psdt_if.sv]
// Request and response channel interfaces with valid/ready handshake.
// Depends on psdt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface psdt_req_if import psdt_pkg::*;;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic               key_present;
   logic [KEY_W-1:0]   producer_key;
   logic [SEQ_W-1:0]   sequence_req;
   logic [CNT_W-1:0]   keep_count;

   modport source (output valid, opcode, key_present, producer_key, sequence_req,
                   keep_count, input ready);
   modport sink   (input valid, opcode, key_present, producer_key, sequence_req,
                   keep_count, output ready);
endinterface

interface psdt_rsp_if import psdt_pkg::*;;
   logic               valid;
   logic               ready;
   logic               is_duplicate;
   logic               table_full;
   logic [CNT_W-1:0]   producer_count;
   logic [CNT_W-1:0]   removed_count;

   modport source (output valid, is_duplicate, table_full, producer_count,
                   removed_count, input ready);
   modport sink   (input valid, is_duplicate, table_full, producer_count,
                   removed_count, output ready);
endinterface

`default_nettype wire

[rtl/psdt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/psdt_ctrl.sv]
// Controller state machine: accept, table scan, update, response.
// Depends on psdt_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module psdt_ctrl import psdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_APPLY,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_START;
         ST_START: state_in = status.need_scan ? ST_SCAN : ST_RESP;
         ST_SCAN:  if (status.scan_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_APPLY;
         ST_APPLY: state_in = status.is_cleanup ? ST_START : ST_RESP;
         ST_RESP:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshake and datapath commands.
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign cmd.load       = req_valid && req_ready;
   assign cmd.scan_clear = (state_ff == ST_START) && status.need_scan;
   assign cmd.scan_issue = (state_ff == ST_SCAN);
   assign cmd.apply      = (state_ff == ST_APPLY);

endmodule

`default_nettype wire

[rtl/psdt_datapath.sv]
// Datapath: request registers, entry RAM, valid bits, scan and update logic.
// Depends on psdt_pkg, psdt_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "producer_sequence_dedup_table_assert.svh"

module psdt_datapath import psdt_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [1:0]         req_opcode,
   input  logic               req_key_present,
   input  logic [KEY_W-1:0]   req_producer_key,
   input  logic [SEQ_W-1:0]   req_sequence_req,
   input  logic [CNT_W-1:0]   req_keep_count,
   output logic               rsp_is_duplicate,
   output logic               rsp_table_full,
   output logic [CNT_W-1:0]   rsp_producer_count,
   output logic [CNT_W-1:0]   rsp_removed_count
);

   localparam int IW = $clog2(ENTRIES);
   localparam int LW = $clog2(ENTRIES + 1);
   localparam int CW = (LW > CNT_W) ? LW : CNT_W;
   localparam int RW = KEY_W + SEQ_W + STAMP_W;

   // Request registers.
   opcode_type          op_ff, op_in;
   logic                present_ff, present_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [CNT_W-1:0]    keep_ff, keep_in;

   // Table state.
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [CW-1:0]       live_ff, live_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;

   // Scan state.
   logic [IW-1:0]       idx_ff, idx_in;
   logic                data_vld_ff, data_vld_in;
   logic [IW-1:0]       data_idx_ff, data_idx_in;
   logic                match_found_ff, match_found_in;
   logic [IW-1:0]       match_slot_ff, match_slot_in;
   logic [SEQ_W-1:0]    match_max_ff, match_max_in;
   logic                free_found_ff, free_found_in;
   logic [IW-1:0]       free_slot_ff, free_slot_in;
   logic                best_found_ff, best_found_in;
   logic [IW-1:0]       best_slot_ff, best_slot_in;
   logic [STAMP_W-1:0]  best_age_ff, best_age_in;

   // Response registers.
   logic                dup_ff, dup_in;
   logic                full_ff, full_in;
   logic [CW-1:0]       removed_ff, removed_in;

   // RAM ports and decoded read fields.
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   logic [RW-1:0]       wr_data;
   logic [RW-1:0]       rd_data;
   logic [KEY_W-1:0]    rd_key;
   logic [SEQ_W-1:0]    rd_max;
   logic [STAMP_W-1:0]  rd_stamp;
   logic [STAMP_W-1:0]  rd_age;
   logic                rd_valid;
   logic [SEQ_W-1:0]    new_max;

   psdt_ram #(
      .WIDTH (RW),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.scan_issue),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_key   = rd_data[RW-1 -: KEY_W];
   assign rd_max   = rd_data[STAMP_W +: SEQ_W];
   assign rd_stamp = rd_data[STAMP_W-1:0];
   assign rd_age   = stamp_ff - rd_stamp;
   assign rd_valid = valid_ff[data_idx_ff];

   // A mark of a known key keeps the larger sequence; a new entry starts at the requested sequence.
   assign new_max = (match_found_ff && (match_max_ff > seq_ff)) ? match_max_ff : seq_ff;

   assign wr_addr = match_found_ff ? match_slot_ff : free_slot_ff;
   assign wr_data = {key_ff, new_max, stamp_ff};
   assign wr_en   = cmd.apply && (op_ff == OP_MARK) && (match_found_ff || free_found_ff);

   // Status to the controller.
   assign status.is_cleanup = (op_ff == OP_CLEANUP);
   assign status.need_scan  = (op_ff == OP_CLEANUP) ? (live_ff > CW'(keep_ff)) : present_ff;
   assign status.scan_last  = (idx_ff == IW'(ENTRIES - 1));

   // Next-state logic for request capture, scan and table update.
   always_comb begin
      op_in          = op_ff;
      present_in     = present_ff;
      key_in         = key_ff;
      seq_in         = seq_ff;
      keep_in        = keep_ff;
      valid_in       = valid_ff;
      live_in        = live_ff;
      stamp_in       = stamp_ff;
      idx_in         = idx_ff;
      match_found_in = match_found_ff;
      match_slot_in  = match_slot_ff;
      match_max_in   = match_max_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      best_found_in  = best_found_ff;
      best_slot_in   = best_slot_ff;
      best_age_in    = best_age_ff;
      dup_in         = dup_ff;
      full_in        = full_ff;
      removed_in     = removed_ff;
      data_vld_in    = cmd.scan_issue;
      data_idx_in    = idx_ff;

      if (cmd.load) begin
         op_in      = opcode_type'(req_opcode);
         present_in = req_key_present;
         key_in     = req_producer_key;
         seq_in     = req_sequence_req;
         keep_in    = req_keep_count;
         dup_in     = 1'b0;
         full_in    = 1'b0;
         removed_in = '0;
      end

      if (cmd.scan_clear) begin
         idx_in         = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         best_found_in  = 1'b0;
      end

      if (cmd.scan_issue) begin
         idx_in = idx_ff + 1'b1;
      end

      // Evaluate the entry whose RAM data arrived this cycle.
      if (data_vld_ff) begin
         if (rd_valid && (rd_key == key_ff) && !match_found_ff) begin
            match_found_in = 1'b1;
            match_slot_in  = data_idx_ff;
            match_max_in   = rd_max;
         end
         if (!rd_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = data_idx_ff;
         end
         if (rd_valid && (!best_found_ff || (rd_age > best_age_ff))) begin
            best_found_in = 1'b1;
            best_slot_in  = data_idx_ff;
            best_age_in   = rd_age;
         end
      end

      // Apply the operation once the scan has completed.
      if (cmd.apply) begin
         case (op_ff)
            OP_CHECK: begin
               dup_in = match_found_ff && (seq_ff <= match_max_ff);
            end
            OP_MARK: begin
               if (match_found_ff) begin
                  stamp_in = stamp_ff + 1'b1;
               end else if (free_found_ff) begin
                  valid_in[free_slot_ff] = 1'b1;
                  live_in  = live_ff + 1'b1;
                  stamp_in = stamp_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (match_found_ff) begin
                  valid_in[match_slot_ff] = 1'b0;
                  live_in    = live_ff - 1'b1;
                  removed_in = CW'(1);
               end
            end
            default: begin
               if (best_found_ff) begin
                  valid_in[best_slot_ff] = 1'b0;
                  live_in    = live_ff - 1'b1;
                  removed_in = removed_ff + 1'b1;
               end
            end
         endcase
      end
   end

   // Registers; control state is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         live_ff        <= '0;
         stamp_ff       <= '0;
         data_vld_ff    <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_found_ff  <= 1'b0;
         op_ff          <= OP_CHECK;
         present_ff     <= 1'b0;
         dup_ff         <= 1'b0;
         full_ff        <= 1'b0;
         removed_ff     <= '0;
         idx_ff         <= '0;
      end else begin
         valid_ff       <= valid_in;
         live_ff        <= live_in;
         stamp_ff       <= stamp_in;
         data_vld_ff    <= data_vld_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         best_found_ff  <= best_found_in;
         op_ff          <= op_in;
         present_ff     <= present_in;
         dup_ff         <= dup_in;
         full_ff        <= full_in;
         removed_ff     <= removed_in;
         idx_ff         <= idx_in;
      end
      key_ff        <= key_in;
      seq_ff        <= seq_in;
      keep_ff       <= keep_in;
      data_idx_ff   <= data_idx_in;
      match_slot_ff <= match_slot_in;
      match_max_ff  <= match_max_in;
      free_slot_ff  <= free_slot_in;
      best_slot_ff  <= best_slot_in;
      best_age_ff   <= best_age_in;
   end

   assign rsp_is_duplicate   = dup_ff;
   assign rsp_table_full     = full_ff;
   assign rsp_producer_count = live_ff[CNT_W-1:0];
   assign rsp_removed_count  = removed_ff[CNT_W-1:0];

   // The live count always tracks the number of set valid bits.
   `PSDT_ASSERT_IMP(a_live_matches_valid, clock, reset, 1'b1,
                    $countones(valid_ff) == int'(live_ff))
   // The recency counter moves only when an update is applied.
   `PSDT_ASSERT_NEXT(a_stamp_only_on_apply, clock, reset, !cmd.apply, $stable(stamp_ff))
   // A rejected mark never reports a duplicate.
   `PSDT_ASSERT_IMP(a_full_not_dup, clock, reset, full_ff, !dup_ff)

endmodule

`default_nettype wire

[rtl/producer_sequence_dedup_table.sv]
// Check, mark and remove with a key pass a start step, a scan of every entry, a drain step
// and an apply step before the response; without a key, and cleanup with nothing to evict,
// skip to the response. Cleanup repeats scan and apply per evicted entry. One request is in
// flight at a time; the scan uses the entry RAM's single read port, one entry per cycle.
// Reset (synchronous) empties the table and clears the recency counter at once.
// Top level: controller, datapath and the request/response channels.
`timescale 1ns / 1ps
`default_nettype none

module producer_sequence_dedup_table import psdt_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   psdt_req_if.sink    req_if,
   psdt_rsp_if.source  rsp_if
);

   cmd_type    cmd;
   status_type status;

   // Sequencing of each request.
   psdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table storage and update logic.
   psdt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_if.opcode),
      .req_key_present    (req_if.key_present),
      .req_producer_key   (req_if.producer_key),
      .req_sequence_req   (req_if.sequence_req),
      .req_keep_count     (req_if.keep_count),
      .rsp_is_duplicate   (rsp_if.is_duplicate),
      .rsp_table_full     (rsp_if.table_full),
      .rsp_producer_count (rsp_if.producer_count),
      .rsp_removed_count  (rsp_if.removed_count)
   );

endmodule

`default_nettype wire
